/* hdl/hcis_pkg.sv */
// Package: shared types and constants of the accumulator core step block.
`timescale 1ns / 1ps
package hcis_pkg;

   localparam int unsigned IP_W  = 9;
   localparam int unsigned RA_W  = 6;
   localparam int unsigned CNT_W = 5;

   localparam logic [15:0] INS_ENTRY  = 16'hffdf;
   localparam logic [15:0] INS_NOP    = 16'h7fff;
   localparam logic [15:0] INS_RETURN = 16'hffff;
   localparam logic [15:0] INS_ROTATE = 16'hbf82;

   localparam logic [5:0] OPC_ACC    = 6'd60;
   localparam logic [5:0] OPC_PTR    = 6'd61;
   localparam logic [5:0] OPC_AT     = 6'd62;
   localparam logic [5:0] OPC_AT_INC = 6'd63;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_NESTED  = 3'd1;
   localparam logic [2:0] ERR_STRAY   = 3'd2;
   localparam logic [2:0] ERR_RANGE   = 3'd3;
   localparam logic [2:0] ERR_RX_DONE = 3'd4;
   localparam logic [2:0] ERR_BUSY    = 3'd5;

   localparam logic [2:0] CSR_SHIFT0 = 3'd0;
   localparam logic [2:0] CSR_SHIFT1 = 3'd1;
   localparam logic [2:0] CSR_SHIFT2 = 3'd2;
   localparam logic [2:0] CSR_SHIFT3 = 3'd3;
   localparam logic [2:0] CSR_TEST   = 3'd4;

   localparam logic [3:0] K_NOP    = 4'd0;
   localparam logic [3:0] K_ENTRY  = 4'd1;
   localparam logic [3:0] K_RETURN = 4'd2;
   localparam logic [3:0] K_JMP_T  = 4'd3;
   localparam logic [3:0] K_JMP_F  = 4'd4;
   localparam logic [3:0] K_ROTATE = 4'd5;
   localparam logic [3:0] K_STB_T  = 4'd6;
   localparam logic [3:0] K_STB_F  = 4'd7;
   localparam logic [3:0] K_IMM    = 4'd8;
   localparam logic [3:0] K_ALU    = 4'd9;

   typedef struct packed {
      logic [15:0] instr;
      logic [31:0] const_word;
      logic        rx_has_word;
      logic [31:0] rx_word;
      logic        rx_more;
   } req_type;

   typedef struct packed {
      logic [8:0]  next_ip;
      logic        tx_valid;
      logic [31:0] tx_word;
      logic [2:0]  error;
      logic [31:0] acc_value;
   } rsp_type;

   typedef struct packed {
      req_type    req;
      logic [3:0] kind;
   } slot_type;

   function automatic logic [3:0] classify(input logic [15:0] c);
      logic [3:0] k;
      begin
         k = K_NOP;
         if (c == INS_ENTRY) k = K_ENTRY;
         else if (c == INS_NOP) k = K_NOP;
         else if (c == INS_RETURN) k = K_RETURN;
         else if ((c & 16'hc000) == 16'h4000) k = K_JMP_T;
         else if ((c & 16'hc000) == 16'h0000) k = K_JMP_F;
         else if (c == INS_ROTATE) k = K_ROTATE;
         else if ((c & 16'hc1c0) == 16'hc180) k = K_STB_T;
         else if ((c & 16'hc1c0) == 16'h8180) k = K_STB_F;
         else if ((c & 16'h8100) == 16'h8000) k = K_IMM;
         else if ((c & 16'h8180) == 16'h8100) k = K_ALU;
         return k;
      end
   endfunction

   function automatic logic [31:0] bit_rev(input logic [31:0] v);
      logic [31:0] r;
      begin
         for (int i = 0; i < 32; i++) r[i] = v[31 - i];
         return r;
      end
   endfunction

endpackage

/* hdl/hash_core_instruction_step_top.sv */
// Top level: config registers, decode front end, queue and execute back end.
`timescale 1ns / 1ps
// Each item is accepted into the queue, then passes the read, execute, port
// and done phases of the back end before its result is registered.
// The back end takes a new instruction only after the done phase of the last; a
// stalled result holds the back end and the 2-entry queue then stalls input.
// Reset (synchronous, active high) clears pointers, flags, queue, config
// registers and RAM valid bits; unwritten RAM words read zero.
module hash_core_instruction_step_top
   import hcis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [5:0]  csr_data
);

   logic [5:0] sh0_ff, sh1_ff, sh2_ff, sh3_ff;
   logic       test_ff;
   logic       push, full, pop, nonempty;
   slot_type   push_slot, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         sh0_ff <= '0; sh1_ff <= '0; sh2_ff <= '0; sh3_ff <= '0;
         test_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SHIFT0: sh0_ff <= csr_data;
            CSR_SHIFT1: sh1_ff <= csr_data;
            CSR_SHIFT2: sh2_ff <= csr_data;
            CSR_SHIFT3: sh3_ff <= csr_data;
            CSR_TEST:   test_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   hcis_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .push, .push_slot, .full
   );

   hcis_queue u_queue (
      .clock, .reset, .push, .push_slot, .full, .pop, .nonempty, .head
   );

   hcis_back u_back (
      .clock, .reset, .nonempty, .head, .pop,
      .shift0(sh0_ff), .shift1(sh1_ff), .shift2(sh2_ff), .shift3(sh3_ff),
      .test_mode(test_ff), .rsp_valid, .rsp_stall, .rsp_payload
   );

endmodule

/* hdl/hcis_front.sv */
// Front end: accept items, decode the instruction class, fill the queue.
`timescale 1ns / 1ps
module hcis_front
   import hcis_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   output logic     push,
   output slot_type push_slot,
   input  logic     full
);

   assign req_stall = full;
   assign push = req_valid && !full;
   assign push_slot.req = req_payload;
   assign push_slot.kind = classify(req_payload.instr);

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_push_is_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> push) else $error("accept without push");
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> req_stall) else $error("no stall while full");

endmodule

/* hdl/hcis_queue.sv */
// Two-entry queue between decode and execute.
`timescale 1ns / 1ps
module hcis_queue
   import hcis_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  slot_type push_slot,
   output logic     full,
   input  logic     pop,
   output logic     nonempty,
   output slot_type head
);

   slot_type   slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = cnt_ff == 2'd2;
   assign nonempty = cnt_ff != 2'd0;
   assign head = slot_ff[rd_ff];

   always_comb begin
      wr_in = push ? !wr_ff : wr_ff;
      rd_in = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_slot;
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> nonempty) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> nonempty) else $error("push lost");

endmodule

/* hdl/hcis_back.sv */
// Back end: execute one instruction at a time in read, execute, port and done phases and hold the result register.
`timescale 1ns / 1ps
module hcis_back
   import hcis_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     nonempty,
   input  slot_type head,
   output logic     pop,
   input  logic [5:0] shift0,
   input  logic [5:0] shift1,
   input  logic [5:0] shift2,
   input  logic [5:0] shift3,
   input  logic     test_mode,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   localparam logic [1:0] PH_READ = 2'd0;
   localparam logic [1:0] PH_EXEC = 2'd1;
   localparam logic [1:0] PH_PORT = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   // data RAM: one registered read and one write per cycle; words 0..31 are
   // addressed through a rotation offset so the rotate only bumps the offset
   logic [31:0] ram [64];
   logic [63:0] vld_ff;
   logic [31:0] rdata_ff;
   logic        rvld_ff;
   logic        mem_re, mem_we;
   logic [RA_W-1:0] mem_ra, mem_wa;
   logic [31:0] mem_wd, mdata;

   logic [1:0]  ph_ff, ph_in;
   logic [4:0]  rot_ff, rot_in;
   logic        prx_ff, prx_in, ptx_ff, ptx_in;
   logic [RA_W-1:0] pa_ff, pa_in;
   logic [31:0] pwd_ff, pwd_in;
   logic        iwe;
   logic [RA_W-1:0] iwa;
   logic [31:0] iwd;

   logic [31:0] acc_ff, acc_in, vis_ff, vis_in, pend_ff, pend_in;
   logic [RA_W-1:0] ptr_ff, ptr_in;
   logic [IP_W-1:0] ip_ff, ip_in, ra_ff, ra_in, pnip_ff, pnip_in;
   logic sub_ff, sub_in, rx_ff, rx_in, tx_ff, tx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic    ov_ff, ov_in;
   rsp_type out_ff, out_in, res_ff, res_in;

   logic [15:0] c;
   logic [5:0]  addr, y, d;
   logic        flag, cin, serve, rw, to_acc, nc;
   logic [2:0]  err;
   logic [31:0] regv, s, s1, r, u;
   logic [32:0] wide;
   logic [6:0]  t;
   logic        txv;

   assign rsp_valid = ov_ff;
   assign rsp_payload = out_ff;

   function automatic logic [RA_W-1:0] phys(input logic [RA_W-1:0] a,
      input logic [4:0] rot);
      logic [4:0] lo;
      begin
         lo = a[4:0] + rot;
         return a[5] ? a : {1'b0, lo};
      end
   endfunction

   always_comb begin
      c = head.req.instr;
      addr = c[14:9];
      y = c[5:0];
      rw = c[6];
      flag = vis_ff[c[13:9]];
      mdata = rvld_ff ? rdata_ff : 32'd0;
      acc_in = acc_ff; ptr_in = ptr_ff; ra_in = ra_ff; sub_in = sub_ff;
      pnip_in = pnip_ff; pend_in = pend_ff; rx_in = rx_ff; tx_in = tx_ff;
      cnt_in = cnt_ff; rot_in = rot_ff;
      vis_in = pend_ff;
      cin = pend_ff[1];
      ip_in = ip_ff + 1'b1;
      err = ERR_NONE; serve = 1'b1; txv = 1'b0;
      iwe = 1'b0; iwa = phys(ptr_ff, rot_ff); iwd = {24'd0, c[7:0]};
      prx_in = 1'b0; ptx_in = 1'b0; pa_in = '0; pwd_in = head.req.rx_word;
      if (addr == OPC_ACC) regv = acc_ff;
      else if (addr == OPC_PTR) regv = {26'd0, ptr_ff};
      else regv = mdata;
      s = 32'd0; s1 = 32'd0; r = 32'd0; u = 32'd0; nc = 1'b0; to_acc = 1'b0;
      d = 6'd0; wide = 33'd0; t = 7'd0;
      if (head.kind == K_ENTRY) begin
         if (!sub_ff) begin
            ra_in = pnip_ff; sub_in = 1'b1;
         end else begin
            err = ERR_NESTED; serve = 1'b0;
         end
      end else begin
         pnip_in = ip_in;
         unique case (head.kind)
            K_RETURN: begin
               if (!sub_ff) begin
                  err = ERR_STRAY; serve = 1'b0;
               end else begin
                  ip_in = ra_ff; sub_in = 1'b0;
               end
            end
            K_JMP_T: if (flag) ip_in = c[8:0];
            K_JMP_F: if (!flag) ip_in = c[8:0];
            K_ROTATE: rot_in = rot_ff + 5'd1;
            K_STB_T, K_STB_F: begin
               if (flag == (head.kind == K_STB_T)) begin
                  if (rx_ff || tx_ff) err = ERR_BUSY;
                  else if (y <= 6'd1) begin
                     if (y == 6'd0) rx_in = 1'b1;
                     else tx_in = 1'b1;
                     cnt_in = '0;
                     pend_in[2] = 1'b0; pend_in[3] = 1'b0;
                  end
               end
            end
            K_IMM: begin
               if (addr == OPC_ACC) acc_in = {24'd0, c[7:0]};
               else if (addr == OPC_PTR) ptr_in = c[5:0];
               else if (addr == OPC_AT) iwe = 1'b1;
               else if (addr == OPC_AT_INC) begin
                  iwe = 1'b1;
                  t = {1'b0, ptr_ff} + 7'd1;
                  ptr_in = t[5:0];
                  if (t >= 7'd60) begin
                     err = ERR_RANGE; serve = 1'b0;
                  end
               end else begin
                  iwe = 1'b1; iwa = phys(addr, rot_ff);
               end
            end
            K_ALU: begin
               if (y == 6'd32 && rw) begin
                  s1 = acc_ff; s = regv; to_acc = 1'b0;
               end else begin
                  s = acc_ff; s1 = regv; to_acc = !rw;
               end
               if (y > 6'd32) begin
                  r = (s1 << y[4:0]) | (s1 >> (6'd32 - {1'b0, y[4:0]}));
               end else if (y == 6'd32) r = s1;
               else if (y == 6'd0) begin
                  wide = {1'b0, s1} + {1'b0, ~s} + 33'd1;
                  r = wide[31:0];
                  u = ~s + 32'd1;
                  nc = (r < s1) || (r < u);
               end else if (y == 6'd1) r = s ^ s1;
               else if (y == 6'd2) begin
                  wide = {1'b0, s} + {1'b0, s1} + {32'd0, cin};
                  r = wide[31:0];
                  nc = (r < s) || (r < s1) || (r < {31'd0, cin});
               end else if (y == 6'd3) begin
                  wide = {1'b0, s} + {1'b0, s1};
                  r = wide[31:0];
                  nc = wide[32];
               end else if (y == 6'd4) r = s1 - 32'd1;
               else if (y == 6'd5) r = s1 + 32'd1;
               else if (y == 6'd6) begin
                  nc = s1[31]; r = {s1[30:0], cin};
               end else if (y == 6'd7) begin
                  nc = s1[31]; r = {s1[30:0], 1'b0};
               end else if (y == 6'd8) r = s & s1;
               else if (y == 6'd9) r = s | s1;
               else if (y == 6'd10) r = ~s1;
               else if (y == 6'd11) r = bit_rev(s1);
               else if (y <= 6'd15) begin
                  unique case (y[1:0])
                     2'd0: d = shift0;
                     2'd1: d = shift1;
                     2'd2: d = shift2;
                     default: d = shift3;
                  endcase
                  r = d[5] ? (s1 >> d[4:0]) : (s1 << d[4:0]);
               end else r = head.req.const_word;
               iwd = r;
               if (to_acc) acc_in = r;
               else if (addr < OPC_ACC) begin
                  iwe = 1'b1; iwa = phys(addr, rot_ff);
               end else if (addr == OPC_ACC) acc_in = r;
               else if (addr == OPC_PTR) ptr_in = r[5:0];
               else iwe = 1'b1;
               if (addr == OPC_AT_INC) ptr_in = ptr_ff + 1'b1;
               if (y < 6'd10) begin
                  pend_in[0] = r == 32'd0;
                  if (y == 6'd0 || y == 6'd2 || y == 6'd3 || y == 6'd6 || y == 6'd7)
                     pend_in[1] = nc;
               end
            end
            default: ;
         endcase
      end
      // port word moves in the following cycle, after the instruction write
      if (serve && rx_in) begin
         prx_in = 1'b1; pa_in = phys(ptr_in, rot_in);
         ptr_in = ptr_in + 1'b1;
         if (!head.req.rx_has_word) begin
            rx_in = 1'b0;
            if (err == ERR_NONE) err = ERR_RX_DONE;
         end
         if (cnt_in == 5'd15) begin
            if (!head.req.rx_has_word || !head.req.rx_more || test_mode)
               pend_in[3] = 1'b1;
            else pend_in[2] = 1'b1;
            rx_in = 1'b0;
         end
         cnt_in = cnt_in + 1'b1;
      end else if (serve && tx_in) begin
         cnt_in = cnt_in + 1'b1;
         ptx_in = 1'b1; pa_in = phys(ptr_in, rot_in);
         txv = 1'b1;
         ptr_in = ptr_in + 1'b1;
         if (cnt_in == 5'd8) begin
            tx_in = 1'b0; pend_in[3] = 1'b1;
         end
      end
      res_in.next_ip = ip_in;
      res_in.tx_valid = txv;
      res_in.tx_word = 32'd0;
      res_in.error = err;
      res_in.acc_value = acc_in;
   end

   always_comb begin
      ph_in = ph_ff; pop = 1'b0; mem_re = 1'b0; mem_we = 1'b0;
      mem_ra = (addr < OPC_ACC) ? phys(addr, rot_ff) : phys(ptr_ff, rot_ff);
      mem_wa = iwa; mem_wd = iwd;
      out_in = res_ff;
      out_in.tx_word = res_ff.tx_valid ? mdata : 32'd0;
      unique case (ph_ff)
         PH_READ: begin
            if (nonempty) begin
               mem_re = 1'b1; ph_in = PH_EXEC;
            end
         end
         PH_EXEC: begin
            mem_we = iwe; ph_in = PH_PORT;
         end
         PH_PORT: begin
            mem_ra = pa_ff; mem_re = ptx_ff;
            mem_wa = pa_ff; mem_wd = pwd_ff; mem_we = prx_ff;
            ph_in = PH_DONE;
         end
         default: begin
            // hold the item until the result register is free
            if (!ov_ff || !rsp_stall) begin
               pop = 1'b1; ph_in = PH_READ;
            end
         end
      endcase
      ov_in = pop ? 1'b1 : (ov_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (mem_we) ram[mem_wa] <= mem_wd;
      if (mem_re) rdata_ff <= ram[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0; rvld_ff <= 1'b0; ph_ff <= PH_READ; rot_ff <= '0;
         prx_ff <= 1'b0; ptx_ff <= 1'b0;
         acc_ff <= '0; vis_ff <= '0; pend_ff <= '0; ptr_ff <= '0;
         ip_ff <= '0; ra_ff <= '0; pnip_ff <= '0; sub_ff <= 1'b0;
         rx_ff <= 1'b0; tx_ff <= 1'b0; cnt_ff <= '0; ov_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         ov_ff <= ov_in;
         if (mem_we) vld_ff[mem_wa] <= 1'b1;
         if (mem_re) rvld_ff <= vld_ff[mem_ra];
         if (ph_ff == PH_EXEC) begin
            acc_ff <= acc_in; vis_ff <= vis_in; pend_ff <= pend_in;
            ptr_ff <= ptr_in; ip_ff <= ip_in; ra_ff <= ra_in;
            pnip_ff <= pnip_in; sub_ff <= sub_in; rx_ff <= rx_in;
            tx_ff <= tx_in; cnt_ff <= cnt_in; rot_ff <= rot_in;
            prx_ff <= prx_in; ptx_ff <= ptx_in;
         end
      end
      if (ph_ff == PH_EXEC) begin
         res_ff <= res_in; pa_ff <= pa_in; pwd_ff <= pwd_in;
      end
      if (pop) out_ff <= out_in;
   end

   a_ports_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(rx_ff && tx_ff)) else $error("both ports active");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |-> !pop) else $error("result overwritten");
   a_tx_only_active: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && out_ff.tx_valid) |-> (out_ff.error != ERR_NESTED))
      else $error("transmit with skipped service");
   a_pop_when_done: assert property (@(posedge clock) disable iff (reset)
      pop |-> (ph_ff == PH_DONE)) else $error("pop outside done phase");

endmodule
